### sv/uart_rx_fifo_register_model_assert.svh
// Assertion macros for the checker file of the UART register block.
// Depends on nothing; include by bare file name inside a module body.
`ifndef UART_RX_FIFO_REGISTER_MODEL_ASSERT_SVH
`define UART_RX_FIFO_REGISTER_MODEL_ASSERT_SVH

// Same-cycle implication, gated off while reset is low.
`define URFRM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("urfrm assertion failed");

// Next-cycle implication, gated off while reset is low.
`define URFRM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("urfrm assertion failed");

`endif

### sv/urfrm_pkg.sv
// Types and codes for the UART register block with receive FIFO.
// No dependencies.
package urfrm_pkg;

    // Item kinds
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Register offsets
    localparam logic [2:0] OFF_DATA = 3'd0;
    localparam logic [2:0] OFF_IER  = 3'd1;
    localparam logic [2:0] OFF_LSR  = 3'd5;

    // Line status bit 0: data ready
    localparam logic [7:0] LSR_DATA_READY = 8'h01;

    // Per-cycle command broadcast to every FIFO cell
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

    // Occupancy seen at the ends of the cell row
    typedef struct packed {
        logic head_full;    // cell 0 holds a byte
        logic second_full;  // cell 1 holds a byte
        logic tail_full;    // last cell holds a byte: FIFO full
    } chain_status_t;

endpackage

### sv/urfrm_cell.sv
// One FIFO cell: a byte and an occupied flag, shifting toward the head on pop.
// Depends on urfrm_pkg.
module urfrm_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  urfrm_pkg::cell_ctrl_t  ctrl,
    input  logic                   prev_full,
    input  logic                   next_full,
    input  logic [7:0]             next_data,
    input  logic [7:0]             push_data,
    output logic                   full,
    output logic [7:0]             data
);
    import urfrm_pkg::*;

    logic       full_reg, full_next;
    logic [7:0] byte_reg, byte_next;

    always_comb begin
        full_next = full_reg;
        byte_next = byte_reg;
        if (ctrl.pop) begin
            full_next = next_full;
            byte_next = next_data;
        end else if (ctrl.push && prev_full && !full_reg) begin
            // first empty slot takes the new byte
            full_next = 1'b1;
            byte_next = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign full = full_reg;
    assign data = byte_reg;

endmodule

### sv/urfrm_chain.sv
// Row of FIFO cells forming the receive FIFO; head at cell 0.
// Depends on urfrm_pkg and urfrm_cell.
module urfrm_chain #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  urfrm_pkg::cell_ctrl_t     ctrl,
    input  logic [7:0]                push_data,
    output urfrm_pkg::chain_status_t  status,
    output logic [7:0]                head_data
);
    import urfrm_pkg::*;

    logic [FIFO_DEPTH-1:0] full_w;
    logic [7:0]            data_w [FIFO_DEPTH];

    for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
        logic       prev_full_w;
        logic       next_full_w;
        logic [7:0] next_data_w;

        if (i == 0) begin : g_head
            assign prev_full_w = 1'b1;
        end else begin : g_body
            assign prev_full_w = full_w[i-1];
        end

        if (i == FIFO_DEPTH - 1) begin : g_tail
            assign next_full_w = 1'b0;
            assign next_data_w = 8'h00;
        end else begin : g_inner
            assign next_full_w = full_w[i+1];
            assign next_data_w = data_w[i+1];
        end

        urfrm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .prev_full (prev_full_w),
            .next_full (next_full_w),
            .next_data (next_data_w),
            .push_data (push_data),
            .full      (full_w[i]),
            .data      (data_w[i])
        );
    end

    assign status.head_full   = full_w[0];
    assign status.second_full = full_w[1];
    assign status.tail_full   = full_w[FIFO_DEPTH-1];
    assign head_data          = data_w[0];

endmodule

### sv/uart_rx_fifo_register_model.sv
// Minimal 16550-style UART register subset with a receive FIFO: host pushes
// of received bytes, guest writes (transmit byte at offset 0, interrupt
// enable at offset 1) and guest reads (FIFO pop at offset 0, line status at
// offset 5, zero elsewhere). The block takes one item every cycle while s_ready
// is high; each item gives exactly one result, held in an output register,
// and s_ready stays high while that register is empty or being drained. The
// receive FIFO is a row of FIFO_DEPTH cells with the head in cell 0: a push
// fills the first empty cell, a pop shifts every cell one place toward the
// head at once, so FIFO depth does not change the rate. A push to a full
// FIFO is dropped and flagged; a pop of an empty FIFO returns 0. Depends on
// urfrm_pkg and urfrm_chain.
module uart_rx_fifo_register_model #(
    parameter int FIFO_DEPTH = 16  // 2 .. 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input items
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [2:0] s_offset,
    input  logic [7:0] s_data,
    // result items
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic       m_data_ready,
    output logic       m_rx_dropped
);
    import urfrm_pkg::*;

    logic          accept;
    cell_ctrl_t    ctrl;
    chain_status_t status;
    logic [7:0]    head_data;

    // next result, computed from the item and FIFO state before it
    logic [7:0] read_data_c;
    logic       tx_valid_c;
    logic [7:0] tx_byte_c;
    logic       data_ready_c;
    logic       rx_dropped_c;
    logic       ier_write_c;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] read_data_reg;
    logic       tx_valid_reg;
    logic [7:0] tx_byte_reg;
    logic       data_ready_reg;
    logic       rx_dropped_reg;

    // interrupt-enable byte; stored only, no output depends on it
    logic [7:0] int_enable_reg, int_enable_next;

    // output slot free or emptying this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        ctrl         = '0;
        read_data_c  = 8'h00;
        tx_valid_c   = 1'b0;
        tx_byte_c    = 8'h00;
        data_ready_c = status.head_full;
        rx_dropped_c = 1'b0;
        ier_write_c  = 1'b0;
        unique case (s_kind)
            KIND_PUSH: begin
                ctrl.push    = accept;
                rx_dropped_c = status.tail_full;
                data_ready_c = 1'b1;  // nonempty after any push
            end
            KIND_WRITE: begin
                if (s_offset == OFF_DATA) begin
                    tx_valid_c = 1'b1;
                    tx_byte_c  = s_data;
                end else if (s_offset == OFF_IER) begin
                    ier_write_c = 1'b1;
                end
            end
            KIND_READ: begin
                if (s_offset == OFF_DATA) begin
                    if (status.head_full) begin
                        ctrl.pop     = accept;
                        read_data_c  = head_data;
                        data_ready_c = status.second_full;
                    end
                end else if (s_offset == OFF_LSR) begin
                    read_data_c = status.head_full ? LSR_DATA_READY : 8'h00;
                end
            end
            default: begin
                // unused kind: no state change, status only
            end
        endcase
    end

    urfrm_chain #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .push_data (s_data),
        .status    (status),
        .head_data (head_data)
    );

    always_comb begin
        m_valid_next    = m_valid_reg;
        int_enable_next = int_enable_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            if (ier_write_c) begin
                int_enable_next = s_data;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            int_enable_reg <= 8'h00;
        end else begin
            m_valid_reg    <= m_valid_next;
            int_enable_reg <= int_enable_next;
        end
    end

    // result payload, loaded on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            read_data_reg  <= read_data_c;
            tx_valid_reg   <= tx_valid_c;
            tx_byte_reg    <= tx_byte_c;
            data_ready_reg <= data_ready_c;
            rx_dropped_reg <= rx_dropped_c;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_data  = read_data_reg;
    assign m_tx_valid   = tx_valid_reg;
    assign m_tx_byte    = tx_byte_reg;
    assign m_data_ready = data_ready_reg;
    assign m_rx_dropped = rx_dropped_reg;

endmodule

### sv/urfrm_checker.sv
// Port-level checks for the UART register block, bound to the top level.
// Depends on urfrm_pkg and uart_rx_fifo_register_model_assert.svh.
module urfrm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_kind,
    input logic [2:0] s_offset,
    input logic [7:0] s_data,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_tx_valid,
    input logic [7:0] m_tx_byte,
    input logic       m_data_ready,
    input logic       m_rx_dropped
);
    import urfrm_pkg::*;

    `include "uart_rx_fifo_register_model_assert.svh"

    // stalled item holds
    `URFRM_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_read_data) && $stable(m_tx_byte) && $stable(m_data_ready))

    // transmit write shows up as the next item with its byte
    `URFRM_ASSERT_NEXT(a_tx, aclk, aresetn, s_valid && s_ready && s_kind == KIND_WRITE && s_offset == OFF_DATA, m_valid && m_tx_valid && m_tx_byte == $past(s_data))

    // no transmit, no byte
    `URFRM_ASSERT_NOW(a_tx_zero, aclk, aresetn, m_valid && !m_tx_valid, m_tx_byte == 8'h00)

    // a dropped push only happens into a full, hence nonempty, FIFO
    `URFRM_ASSERT_NOW(a_drop, aclk, aresetn, m_valid && m_rx_dropped, m_data_ready && !m_tx_valid && m_read_data == 8'h00)

endmodule

bind uart_rx_fifo_register_model urfrm_checker u_urfrm_checker (.*);

### dv/tb_uart_rx_fifo_register_model.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UART register block with receive FIFO.
// Depends on urfrm_pkg and uart_rx_fifo_register_model; a shadow FIFO predicts each result.
module tb_uart_rx_fifo_register_model;
    import urfrm_pkg::*;

    localparam int FIFO_DEPTH  = 16;
    localparam int N_DIRECTED  = 28;
    localparam int N_RANDOM    = 522;
    localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake on either side
    localparam int DRAIN_WAIT  = 10;    // extra quiet spell after the last result
    localparam int SRC         = 0;
    localparam int SINK        = 1;

    // codes the package does not name
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [2:0] OFF_SCR     = 3'd7;  // scratch offset: reads 0, writes ignored

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] offset;
        logic [7:0] data;
    } uart_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_ready;
        logic       rx_dropped;
    } uart_result_t;

    // ---------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ---------------------------------------------------------------
    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind = '0;
    logic [2:0] s_offset = '0;
    logic [7:0] s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;
    logic       m_tx_valid;
    logic [7:0] m_tx_byte;
    logic       m_data_ready;
    logic       m_rx_dropped;

    uart_rx_fifo_register_model #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_offset    (s_offset),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_tx_valid  (m_tx_valid),
        .m_tx_byte   (m_tx_byte),
        .m_data_ready(m_data_ready),
        .m_rx_dropped(m_rx_dropped)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Shadow state of the block, updated once per accepted item.
    // ---------------------------------------------------------------
    logic [7:0]                        rx_bytes [FIFO_DEPTH];
    int unsigned                       rx_head = 0;
    logic [$clog2(FIFO_DEPTH+1)-1:0]   rx_fill = '0;
    logic [7:0]                        ier_shadow = '0;  // stored only, never seen at the outputs

    // coverage tallies for the summary
    int unsigned n_pushes = 0, n_dropped = 0, n_tx = 0, n_pops = 0;
    int unsigned n_empty_reads = 0, n_lsr_set = 0, peak_fill = 0;

    uart_item_t   pending_items [$];     // stimulus not yet offered
    uart_result_t expected_results [$];  // predictions waiting for the result channel
    uart_item_t   cur_item;
    int unsigned  items_planned = 0;
    int unsigned  items_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  error_count = 0;

    // Apply one item to the shadow state and return what the block must answer.
    function automatic uart_result_t predict_uart_result(input uart_item_t it);
        uart_result_t r;
        r = '0;
        case (it.kind)
            KIND_PUSH: begin
                // offset plays no part in a push
                n_pushes++;
                if (rx_fill == FIFO_DEPTH) begin
                    r.rx_dropped = 1'b1;
                    n_dropped++;
                end else begin
                    rx_bytes[(rx_head + rx_fill) % FIFO_DEPTH] = it.data;
                    rx_fill++;
                    if (rx_fill > peak_fill) peak_fill = rx_fill;
                end
            end
            KIND_WRITE: begin
                if (it.offset == OFF_DATA) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = it.data;
                    n_tx++;
                end else if (it.offset == OFF_IER) begin
                    ier_shadow = it.data;
                end
            end
            KIND_READ: begin
                if (it.offset == OFF_DATA) begin
                    if (rx_fill != 0) begin
                        r.read_data = rx_bytes[rx_head];
                        rx_head = (rx_head + 1) % FIFO_DEPTH;
                        rx_fill--;
                        n_pops++;
                    end else begin
                        n_empty_reads++;
                    end
                end else if (it.offset == OFF_LSR) begin
                    r.read_data = (rx_fill != 0) ? LSR_DATA_READY : 8'h00;
                    if (rx_fill != 0) n_lsr_set++;
                end
            end
            default: ;  // unused kind: no state change
        endcase
        r.data_ready = (rx_fill != 0);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Idle lengths shared by both sides: mostly none or short, a few long,
    // and now and then a calm stretch with no idling at all.
    // ---------------------------------------------------------------
    int unsigned calm_left [2] = '{0, 0};

    function automatic int unsigned pick_gap(input int side);
        int unsigned r;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic add_item(input logic [1:0] kind, input logic [2:0] offset,
                            input logic [7:0] data);
        uart_item_t it;
        it.kind   = kind;
        it.offset = offset;
        it.data   = data;
        pending_items.push_back(it);
        items_planned++;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: offers the next pending item, holds it until accepted, and
    // predicts the result at the edge where the item is taken.
    // ---------------------------------------------------------------
    int unsigned src_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_uart_result(cur_item));
                items_sent++;
                src_gap = pick_gap(SRC);
            end
            if (s_valid && !s_ready) begin
                // item still waiting: payload and valid stay put
            end else if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_kind   <= cur_item.kind;
                s_offset <= cur_item.offset;
                s_data   <= cur_item.data;
                s_valid  <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest prediction,
    // then decides m_ready for the next cycle.
    // ---------------------------------------------------------------
    int unsigned  sink_stall = 0;
    uart_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with no item pending, read_data 0x%02h",
                             $time, m_read_data);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data",  want.read_data,  m_read_data);
                    check_field("tx_valid",   want.tx_valid,   m_tx_valid);
                    check_field("tx_byte",    want.tx_byte,    m_tx_byte);
                    check_field("data_ready", want.data_ready, m_data_ready);
                    check_field("rx_dropped", want.rx_dropped, m_rx_dropped);
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                sink_stall = pick_gap(SINK);
            end
        end
    end

    // Watchdog: too long with no handshake on either channel ends the run.
    int unsigned idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t ns: no handshake for %0d cycles, %0d items sent, %0d left",
                             $time, IDLE_LIMIT, items_sent, expected_results.size());
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run.
    // ---------------------------------------------------------------
    initial begin
        int unsigned seg, len;
        logic [1:0]  k;
        logic [2:0]  o;

        // directed: empty-FIFO reads, register decode, fill to full, overflow
        add_item(KIND_READ,   OFF_DATA, 8'h00);  // read of empty FIFO returns 0
        add_item(KIND_READ,   OFF_LSR,  8'h00);  // data ready clear
        add_item(KIND_WRITE,  OFF_DATA, 8'hFF);  // transmit, top byte
        add_item(KIND_WRITE,  OFF_DATA, 8'h00);  // transmit, zero byte
        add_item(KIND_WRITE,  OFF_IER,  8'hA5);  // interrupt enable stored only
        add_item(KIND_READ,   OFF_IER,  8'hFF);  // IER reads back as 0
        add_item(KIND_WRITE,  OFF_SCR,  8'h5A);  // write elsewhere ignored
        add_item(KIND_UNUSED, OFF_LSR,  8'hFF);  // unused kind does nothing
        add_item(KIND_PUSH,   OFF_SCR,  8'hFF);  // offset ignored on a push
        add_item(KIND_PUSH,   OFF_DATA, 8'h00);
        repeat (FIFO_DEPTH - 2) add_item(KIND_PUSH, 3'($urandom_range(0, 7)),
                                         8'($urandom_range(0, 255)));
        add_item(KIND_PUSH,   OFF_DATA, 8'h3C);  // full: dropped and flagged
        add_item(KIND_READ,   OFF_LSR,  8'h00);  // data ready set
        add_item(KIND_READ,   OFF_DATA, 8'h00);  // pops the first byte
        add_item(KIND_READ,   OFF_SCR,  8'h00);  // read elsewhere returns 0

        // random: bursts of pushes and pops so the FIFO swings between empty
        // and full, mixed with decoded and undecoded accesses
        while (items_planned < N_DIRECTED + N_RANDOM) begin
            seg = $urandom_range(0, 99);
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
                if (seg < 30) begin
                    k = KIND_PUSH;
                    o = 3'($urandom_range(0, 7));
                end else if (seg < 55) begin
                    k = KIND_READ;
                    o = ($urandom_range(0, 9) == 0) ? OFF_LSR : OFF_DATA;
                end else begin
                    k = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0: o = OFF_DATA;
                        1: o = OFF_IER;
                        2: o = OFF_LSR;
                        default: o = 3'($urandom_range(0, 7));
                    endcase
                end
                add_item(k, o, 8'($urandom_range(0, 255)));
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // all items taken, every prediction answered, then a short quiet spell
        while (items_sent != items_planned) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Ran %0d items, %0d results: %0d pushes (%0d dropped when full), %0d pops,",
                 items_sent, results_seen, n_pushes, n_dropped, n_pops);
        $display("  %0d empty reads, %0d transmits, %0d status reads with data, peak fill %0d",
                 n_empty_reads, n_tx, n_lsr_set, peak_fill);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/urfrm_pkg.sv
sv/urfrm_cell.sv
sv/urfrm_chain.sv
sv/uart_rx_fifo_register_model.sv
sv/urfrm_checker.sv
dv/tb_uart_rx_fifo_register_model.sv
